// File: hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by the front end, the group queue, the back end and the top level.
package jsu_pkg;

    // Most result bytes one input byte can cause (a surrogate pair)
    localparam int MAX_OUT = 4;
    // Default depth of the queue between front and back end; five groups
    // hold the backlog of a surrogate pair followed by plain text
    localparam int QUEUE_DEPTH_DEF = 5;

    // Status codes reported with the final result of a string
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CUT      = 3'd1,
        ST_BAD_HEX  = 3'd2,
        ST_BAD_LOW  = 3'd3,
        ST_LONE_LOW = 3'd4,
        ST_BAD_ESC  = 3'd5,
        ST_CTRL     = 3'd6
    } status_t;

    // Escape parser phase
    typedef enum logic [2:0] {
        PH_TEXT = 3'd0,
        PH_ESC  = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_HEX3 = 3'd4,
        PH_HEX4 = 3'd5
    } phase_t;

    // All results caused by one input byte, as queued for the back end.
    // A group with no bytes only exists at the end of a string and then
    // carries the status.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    last;
        status_t                 status;
    } group_t;

endpackage

// File: hdl/jsu_front.sv
// Front end of the JSON string unescaper: escape parser and UTF-8 encoder.
// Turns each accepted byte into one group of results. Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output group_t     push_data
);

    phase_t      phase_reg, phase_next;
    logic [11:0] hex_acc_reg, hex_acc_next;
    logic        hex_bad_reg, hex_bad_next;
    logic [9:0]  high_sur_reg, high_sur_next;
    logic        pend_reg, pend_next;
    status_t     err_reg, err_next;

    logic [3:0]  digit;
    logic        digit_ok;
    logic [15:0] code;
    logic [10:0] cp_upper;
    logic [20:0] cp;
    group_t      grp;

    // Decode one hex digit, either case
    always_comb begin
        digit    = 4'd0;
        digit_ok = 1'b1;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            digit = 4'(in_byte - 8'h30);
        end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
            digit = 4'(in_byte - 8'h37);
        end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
            digit = 4'(in_byte - 8'h57);
        end else begin
            digit_ok = 1'b0;
        end
    end

    // Code unit once the fourth digit is in; supplementary code point of a pair
    assign code     = {hex_acc_reg, digit};
    assign cp_upper = {1'b0, high_sur_reg} + 11'h040;
    assign cp       = {cp_upper[10:0], code[9:0]};

    // Parse the byte and build its group of results
    always_comb begin
        phase_next    = phase_reg;
        hex_acc_next  = hex_acc_reg;
        hex_bad_next  = hex_bad_reg;
        high_sur_next = high_sur_reg;
        pend_next     = pend_reg;
        err_next      = err_reg;
        grp.bytes     = '0;
        grp.count     = 3'd0;

        if (err_reg == ST_OK) begin
            case (phase_reg)
                PH_TEXT: begin
                    if (in_byte == 8'h5C) begin
                        if (in_last) err_next = ST_CUT;
                        else         phase_next = PH_ESC;
                    end else if (in_byte >= 8'h01 && in_byte <= 8'h1F) begin
                        err_next = ST_CTRL;
                    end else begin
                        grp.bytes[0] = in_byte;
                        grp.count    = 3'd1;
                    end
                end
                PH_ESC: begin
                    phase_next = PH_TEXT;
                    case (in_byte)
                        8'h5C, 8'h22, 8'h2F: begin
                            grp.bytes[0] = in_byte;
                            grp.count    = 3'd1;
                        end
                        8'h62: begin grp.bytes[0] = 8'h08; grp.count = 3'd1; end
                        8'h66: begin grp.bytes[0] = 8'h0C; grp.count = 3'd1; end
                        8'h6E: begin grp.bytes[0] = 8'h0A; grp.count = 3'd1; end
                        8'h72: begin grp.bytes[0] = 8'h0D; grp.count = 3'd1; end
                        8'h74: begin grp.bytes[0] = 8'h09; grp.count = 3'd1; end
                        8'h75: begin
                            if (in_last) begin
                                err_next = ST_CUT;
                            end else begin
                                phase_next   = PH_HEX1;
                                hex_acc_next = 12'd0;
                                hex_bad_next = 1'b0;
                            end
                        end
                        default: err_next = ST_BAD_ESC;
                    endcase
                end
                PH_HEX1, PH_HEX2, PH_HEX3: begin
                    if (!digit_ok) hex_bad_next = 1'b1;
                    else           hex_acc_next = code[11:0];
                    if (in_last) begin
                        err_next = ST_CUT;
                    end else begin
                        phase_next = (phase_reg == PH_HEX1) ? PH_HEX2 :
                                     (phase_reg == PH_HEX2) ? PH_HEX3 : PH_HEX4;
                    end
                end
                PH_HEX4: begin
                    phase_next   = PH_TEXT;
                    hex_bad_next = 1'b0;
                    if (digit_ok) hex_acc_next = code[11:0];
                    if (hex_bad_reg || !digit_ok) begin
                        err_next = ST_BAD_HEX;
                    end else if (pend_reg) begin
                        // Held high surrogate: this must be the low half
                        if (code[15:10] == 6'b110111) begin
                            grp.bytes[0]  = {5'b11110, cp[20:18]};
                            grp.bytes[1]  = {2'b10, cp[17:12]};
                            grp.bytes[2]  = {2'b10, cp[11:6]};
                            grp.bytes[3]  = {2'b10, cp[5:0]};
                            grp.count     = 3'd4;
                            pend_next     = 1'b0;
                            high_sur_next = 10'd0;
                        end else begin
                            err_next = ST_BAD_LOW;
                        end
                    end else if (code[15:10] == 6'b110110) begin
                        high_sur_next = code[9:0];
                        pend_next     = 1'b1;
                    end else if (code[15:10] == 6'b110111) begin
                        err_next = ST_LONE_LOW;
                    end else if (code == 16'd0) begin
                        grp.bytes[0] = 8'h20;
                        grp.count    = 3'd1;
                    end else if (code[15:7] == 9'd0) begin
                        grp.bytes[0] = code[7:0];
                        grp.count    = 3'd1;
                    end else if (code[15:11] == 5'd0) begin
                        grp.bytes[0] = {3'b110, code[10:6]};
                        grp.bytes[1] = {2'b10, code[5:0]};
                        grp.count    = 3'd2;
                    end else begin
                        grp.bytes[0] = {4'b1110, code[15:12]};
                        grp.bytes[1] = {2'b10, code[11:6]};
                        grp.bytes[2] = {2'b10, code[5:0]};
                        grp.count    = 3'd3;
                    end
                end
                default: phase_next = PH_TEXT;
            endcase
        end

        grp.last   = in_last;
        grp.status = err_next;

        // Return to the idle state at the end of each string
        if (in_last) begin
            phase_next    = PH_TEXT;
            hex_acc_next  = 12'd0;
            hex_bad_next  = 1'b0;
            high_sur_next = 10'd0;
            pend_next     = 1'b0;
            err_next      = ST_OK;
        end
    end

    // Queue a group only when the byte causes at least one result or ends the string
    assign push      = in_accept && (grp.count != 3'd0 || in_last);
    assign push_data = grp;

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TEXT;
            hex_acc_reg  <= 12'd0;
            hex_bad_reg  <= 1'b0;
            high_sur_reg <= 10'd0;
            pend_reg     <= 1'b0;
            err_reg      <= ST_OK;
        end else if (in_accept) begin
            phase_reg    <= phase_next;
            hex_acc_reg  <= hex_acc_next;
            hex_bad_reg  <= hex_bad_next;
            high_sur_reg <= high_sur_next;
            pend_reg     <= pend_next;
            err_reg      <= err_next;
        end
    end

endmodule

// File: hdl/jsu_queue.sv
// Short queue of result groups between the front and back end.
// Depends on jsu_pkg for the group type.
module jsu_queue import jsu_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  group_t push_data,
    input  logic   pop,
    output logic   full,
    output logic   head_valid,
    output group_t head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    group_t        entries_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) count_next = count_reg + CW'(1);
        else if (!do_push && do_pop) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hdl/jsu_back.sv
// Back end of the JSON string unescaper: unpacks queued groups into one
// result per cycle unless stalled, via an output register. Uses jsu_pkg.
module jsu_back import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  group_t      head_data,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       byte_valid_reg;
    logic       run_last_reg;
    logic       done_reg;
    status_t    status_reg;

    logic       out_free;
    logic       load;
    logic       is_end;
    logic       no_bytes;

    assign out_free = !valid_reg || m_axis_tready;
    assign load     = out_free && head_valid;
    assign no_bytes = (head_data.count == 3'd0);
    assign is_end   = no_bytes || ({1'b0, idx_reg} + 3'd1 == head_data.count);
    assign pop      = load && is_end;

    // Step through the bytes of the head group
    always_comb begin
        idx_next = idx_reg;
        if (load) idx_next = is_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (out_free) valid_reg <= head_valid;
        end
    end

    // Load the next result into the output register
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg       <= no_bytes ? 8'd0 : head_data.bytes[idx_reg];
            byte_valid_reg <= !no_bytes;
            run_last_reg   <= is_end;
            done_reg       <= is_end && head_data.last;
            status_reg     <= no_bytes ? head_data.status : ST_OK;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, status_reg, run_last_reg, byte_reg};
    assign m_axis_tlast  = done_reg;
    assign m_axis_tuser  = byte_valid_reg;

endmodule

// File: hdl/json_string_unescape_utf8.sv
// JSON string unescaper. Takes one byte of an escaped JSON string per
// transaction (tlast on the final byte) and returns the unescaped bytes,
// with \uXXXX written as UTF-8 and surrogate pairs joined into four bytes.
// Input is taken every cycle while the queue is not full; each byte is
// parsed in the cycle it is accepted and its results (zero to four) go
// into a queue of QUEUE_DEPTH groups. Results leave at one per cycle through
// a registered output while it is not held; with the default depth the queue
// absorbs the burst of a surrogate pair, so the input stalls only when the
// output is held long enough to fill the queue. A byte's results are queued
// as it is accepted, then loaded into the output register behind any earlier
// results. The last result of each string has tlast set and carries the
// status; after the first error in a string, bytes are dropped until its end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
module json_string_unescape_utf8 import jsu_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] run_last, [11:9] status
    output logic        m_axis_tlast,   // string_done
    output logic        m_axis_tuser    // out_byte_valid
);

    logic   in_accept;
    logic   push;
    group_t push_data;
    logic   pop;
    logic   q_full;
    logic   head_valid;
    group_t head_data;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .push      (push),
        .push_data (push_data)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    jsu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: hdl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Sees only the top-level ports.
module jsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // Hold a waiting input transaction
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("waiting input changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // End of string also ends the run of its input byte
    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[8])
        else $error("string end without run end");

    // A result without a byte is only the status at the end of a string
    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
        else $error("empty result before end of string");

    // Status is zero except on a status-only result
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[11:9] == 3'd0
            && m_axis_tdata[15:12] == 4'd0)
        else $error("status on a data result");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
